[sv/shab_pkg.sv]
package shab_pkg;

	localparam int unsigned WORD_W       = 32;
	localparam int unsigned BLOCK_WORDS  = 16;
	localparam int unsigned ROUNDS       = 64;
	localparam int unsigned DIGEST_WORDS = 8;

	localparam int unsigned CNT_W = $clog2(BLOCK_WORDS);
	localparam int unsigned RND_W = $clog2(ROUNDS);
	localparam int unsigned IDX_W = $clog2(DIGEST_WORDS);

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_FOLD  = 4'b0100,
		ST_DUMP  = 4'b1000
	} state_t;

	typedef struct packed {
		logic             load_word;
		logic             init_hash;
		logic             start_block;
		logic             round_en;
		logic [RND_W-1:0] round_idx;
		logic             fold;
		logic             snapshot;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

	localparam word_t INIT_HASH [DIGEST_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

[sv/shab_ctrl.sv]
module shab_ctrl import shab_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    first_of_message,
	input  logic    last_of_message,
	input  status_t status,
	output logic    in_stall,
	output cmd_t    cmd
);

	state_t           state_q, state_next;
	logic [CNT_W-1:0] cnt_q;
	logic [RND_W-1:0] rnd_q;
	logic             last_q;
	logic             accept;
	logic             block_done;
	logic [CNT_W-1:0] cnt_next;

	assign in_stall   = (state_q != ST_LOAD);
	assign accept     = in_valid && (state_q == ST_LOAD);
	assign cnt_next   = first_of_message ? CNT_W'(1) : cnt_q + 1'b1;
	assign block_done = accept && (cnt_next == '0);

	always_comb begin
		cmd.load_word   = accept;
		cmd.init_hash   = accept && first_of_message;
		cmd.start_block = block_done;
		cmd.round_en    = (state_q == ST_ROUND);
		cmd.round_idx   = rnd_q;
		cmd.fold        = (state_q == ST_FOLD);
		cmd.snapshot    = (state_q == ST_DUMP) && !status.out_busy;
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (block_done) begin
					state_next = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (rnd_q == RND_W'(ROUNDS - 1)) begin
					state_next = ST_FOLD;
				end
			end
			ST_FOLD: begin
				state_next = last_q ? ST_DUMP : ST_LOAD;
			end
			ST_DUMP: begin
				if (!status.out_busy) begin
					state_next = ST_LOAD;
				end
			end
			default: state_next = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			rnd_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			if (accept) begin
				cnt_q <= cnt_next;
			end
			if (block_done) begin
				last_q <= last_of_message;
				rnd_q  <= '0;
			end else if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
			end
		end
	end

	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		block_done |=> (state_q == ST_ROUND) && (rnd_q == '0))
		else $error("round sequence did not start at round zero");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) && (rnd_q == RND_W'(ROUNDS - 1)) |=> (state_q == ST_FOLD))
		else $error("final round not followed by the hash update");

	a_dump_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.snapshot |-> last_q)
		else $error("digest captured for a block that was not final");

	a_fold_resume: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD) && !last_q |=> (state_q == ST_LOAD) && (cnt_q == '0))
		else $error("word count not aligned after a block");

endmodule

[sv/shab_dp.sv]
module shab_dp import shab_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  word_t            message_word,
	input  cmd_t             cmd,
	output status_t          status,
	output logic             out_valid,
	input  logic             out_stall,
	output word_t            digest_word,
	output logic [IDX_W-1:0] digest_index,
	output logic             digest_last
);

	word_t            hash_q [DIGEST_WORDS];
	word_t            var_q  [DIGEST_WORDS];
	word_t            win_q  [BLOCK_WORDS];
	word_t            buf_q  [DIGEST_WORDS];
	logic [IDX_W-1:0] idx_q;
	logic             busy_q;
	logic             out_accept;
	word_t            t1;
	word_t            t2;
	word_t            ch;
	word_t            maj;
	word_t            w_next;
	word_t            win_in;

	always_comb begin
		ch     = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
		maj    = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
		t1     = var_q[7] + big_sigma1(var_q[4]) + ch + ROUND_K[cmd.round_idx] + win_q[0];
		t2     = big_sigma0(var_q[0]) + maj;
		w_next = small_sigma1(win_q[BLOCK_WORDS-2]) + win_q[BLOCK_WORDS-7]
			+ small_sigma0(win_q[1]) + win_q[0];
		win_in = cmd.load_word ? message_word : w_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				hash_q[i] <= INIT_HASH[i];
			end
		end else if (cmd.init_hash) begin
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				hash_q[i] <= INIT_HASH[i];
			end
		end else if (cmd.fold) begin
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				hash_q[i] <= hash_q[i] + var_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word || cmd.round_en) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[BLOCK_WORDS-1] <= win_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_block) begin
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				var_q[i] <= hash_q[i];
			end
		end else if (cmd.round_en) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	assign out_accept = busy_q && !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.snapshot) begin
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				buf_q[i] <= hash_q[i];
			end
		end else if (out_accept) begin
			for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (cmd.snapshot) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_accept) begin
			idx_q <= idx_q + 1'b1;
			if (digest_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign status.out_busy = busy_q;
	assign out_valid       = busy_q;
	assign digest_word     = buf_q[0];
	assign digest_index    = idx_q;
	assign digest_last     = (idx_q == IDX_W'(DIGEST_WORDS - 1));

	a_snap_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.snapshot |-> !busy_q)
		else $error("digest captured over an undelivered digest");

	a_snap_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.snapshot |=> busy_q && (idx_q == '0))
		else $error("digest output did not start at word zero");

	a_out_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_accept && digest_last |=> !busy_q)
		else $error("digest output continued past the eighth word");

endmodule

[sv/sha256_block_hasher_unit.sv]
// SHA-256 block hasher for messages that are already padded.
// The input channel takes one 32-bit big-endian message word per request;
// sixteen requests form one block. A request with first_of_message set
// reloads the standard initial hash values and starts a new block with it.
// After the sixteenth word of a block, in_stall stays high while the block is
// compressed: 64 rounds at one round per cycle, then a fold step that adds
// the working variables into the chaining hash. No new word is taken until
// the fold is done.
// If last_of_message was set on the sixteenth word, a dump step copies the
// hash into an eight-word output buffer, and the output channel then gives
// digest words 0 to 7 in order, one per unstalled cycle, digest_last on the eighth.
// The buffer lets the next message load and compress while the digest drains;
// if the receiver stalls so long that the next digest is ready first, the
// block holds in_stall high until the buffer is empty.
// Reset clears all control state, loads the initial hash values and leaves
// no output pending.
module sha256_block_hasher_unit import shab_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  word_t            message_word,
	input  logic             first_of_message,
	input  logic             last_of_message,
	output logic             out_valid,
	input  logic             out_stall,
	output word_t            digest_word,
	output logic [IDX_W-1:0] digest_index,
	output logic             digest_last
);

	cmd_t    cmd;
	status_t status;

	shab_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message),
		.status           (status),
		.in_stall         (in_stall),
		.cmd              (cmd)
	);

	shab_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.message_word (message_word),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest_word  (digest_word),
		.digest_index (digest_index),
		.digest_last  (digest_last)
	);

endmodule
